[hdl/extended_gcd_unit_top_defines.svh]
// Assertion macros shared by the extended gcd unit checkers.
`ifndef EXTENDED_GCD_UNIT_TOP_DEFINES_SVH
`define EXTENDED_GCD_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EGCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extended gcd unit: assertion failed");

// Next-cycle implication, disabled during reset.
`define EGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extended gcd unit: assertion failed");

`endif

[hdl/egcd_pkg.sv]
// Shared types, widths and the control store of the extended gcd unit.
`timescale 1ns / 1ps

package egcd_pkg;

    localparam int GCD_W  = 31;
    localparam int COEF_W = 32;
    localparam int PC_W   = 3;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_S,
        OP_SUB_S,
        OP_MUL_T,
        OP_ADVANCE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_JZ,
        COND_LOOP,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctl_t;

    typedef struct packed {
        logic rem_zero;
        logic div_last;
        logic out_busy;
    } stat_t;

    localparam pc_t PC_IDLE = pc_t'(0);
    localparam pc_t PC_TEST = pc_t'(1);
    localparam pc_t PC_DIV  = pc_t'(2);
    localparam pc_t PC_EMIT = pc_t'(7);

    // Microprogram: one Euclid step is test, divide, two multiply/subtract pairs.
    function automatic ctrl_word_t egcd_rom(input pc_t pc);
        ctrl_word_t cw;
        unique case (pc)
            3'd0: cw = '{op: OP_LOAD,     cond: COND_WAIT_IN,  target: PC_IDLE};
            3'd1: cw = '{op: OP_DIV_INIT, cond: COND_JZ,       target: PC_EMIT};
            3'd2: cw = '{op: OP_DIV_STEP, cond: COND_LOOP,     target: PC_DIV};
            3'd3: cw = '{op: OP_MUL_S,    cond: COND_NEXT,     target: PC_IDLE};
            3'd4: cw = '{op: OP_SUB_S,    cond: COND_NEXT,     target: PC_IDLE};
            3'd5: cw = '{op: OP_MUL_T,    cond: COND_NEXT,     target: PC_IDLE};
            3'd6: cw = '{op: OP_ADVANCE,  cond: COND_JUMP,     target: PC_TEST};
            3'd7: cw = '{op: OP_EMIT,     cond: COND_WAIT_OUT, target: PC_EMIT};
        endcase
        return cw;
    endfunction

endpackage

[hdl/egcd_seq.sv]
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module egcd_seq
    import egcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  in_stall
);

    pc_t        pc_reg;
    pc_t        pc_next;
    pc_t        pc_inc;
    ctrl_word_t cw;

    // Last step wraps to the idle step through the natural counter overflow.
    assign pc_inc   = pc_reg + pc_t'(1);
    assign cw       = egcd_rom(pc_reg);
    assign in_stall = (pc_reg != PC_IDLE);

    always_comb
    begin
        ctl.op   = cw.op;
        ctl.fire = 1'b1;
        pc_next  = pc_inc;
        unique case (cw.cond)
            COND_NEXT:     pc_next = pc_inc;
            COND_JUMP:     pc_next = cw.target;
            COND_JZ:       pc_next = stat.rem_zero ? cw.target : pc_inc;
            COND_LOOP:     pc_next = stat.div_last ? pc_inc : cw.target;
            COND_WAIT_IN:
            begin
                pc_next  = in_valid ? pc_inc : cw.target;
                ctl.fire = in_valid;
            end
            COND_WAIT_OUT:
            begin
                pc_next  = stat.out_busy ? cw.target : pc_inc;
                ctl.fire = !stat.out_busy;
            end
            default:       pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[hdl/egcd_dp.sv]
// Datapath: remainders, restoring divider, shared multiplier, coefficients, output register.
`timescale 1ns / 1ps

module egcd_dp
    import egcd_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  logic [GCD_W-1:0]  first_operand,
    input  logic [GCD_W-1:0]  second_operand,
    input  logic              out_stall,
    output stat_t             stat,
    output logic              out_valid,
    output logic [GCD_W-1:0]  gcd_value,
    output logic [COEF_W-1:0] coef_first_bits,
    output logic [COEF_W-1:0] coef_second_bits
);

    localparam int W     = VALUE_BITS;
    localparam int CNT_W = $clog2(W);
    localparam int IN_W  = (W < GCD_W) ? W : GCD_W;
    localparam int OUT_W = (W < GCD_W) ? W : GCD_W;
    localparam int Q_W   = (W < COEF_W) ? W : COEF_W;

    logic [W-1:0]      rem_prev_reg;
    logic [W-1:0]      rem_cur_reg;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [COEF_W-1:0] s_prev_reg;
    logic [COEF_W-1:0] s_cur_reg;
    logic [COEF_W-1:0] t_prev_reg;
    logic [COEF_W-1:0] t_cur_reg;
    logic [COEF_W-1:0] prod_reg;
    logic [GCD_W-1:0]  gcd_reg;
    logic [COEF_W-1:0] coef_first_reg;
    logic [COEF_W-1:0] coef_second_reg;
    logic              out_valid_reg;

    logic [W:0]        rem_shift;
    logic [W:0]        trial;
    logic [COEF_W-1:0] q_lo;
    logic [COEF_W-1:0] mul_b;
    logic [COEF_W-1:0] prod_next;
    logic              emit;

    // One quotient bit per step; trial sign says whether the divisor fit.
    assign rem_shift = {acc_reg, quo_reg[W-1]};
    assign trial     = rem_shift - {1'b0, rem_cur_reg};

    // Coefficients are kept modulo 2^32, so only the low quotient bits matter.
    assign q_lo      = COEF_W'(quo_reg[Q_W-1:0]);
    assign mul_b     = (ctl.op == OP_MUL_T) ? t_cur_reg : s_cur_reg;
    assign prod_next = q_lo * mul_b;

    assign emit = ctl.fire && (ctl.op == OP_EMIT);

    assign stat.rem_zero = (rem_cur_reg == '0);
    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            unique case (ctl.op)
                OP_NOP:
                begin
                end
                OP_LOAD:
                begin
                    rem_prev_reg <= W'(first_operand[IN_W-1:0]);
                    rem_cur_reg  <= W'(second_operand[IN_W-1:0]);
                    s_prev_reg   <= COEF_W'(1);
                    t_prev_reg   <= '0;
                    s_cur_reg    <= '0;
                    t_cur_reg    <= COEF_W'(1);
                end
                OP_DIV_INIT:
                begin
                    acc_reg <= '0;
                    quo_reg <= rem_prev_reg;
                    cnt_reg <= CNT_W'(W - 1);
                end
                OP_DIV_STEP:
                begin
                    acc_reg <= trial[W] ? rem_shift[W-1:0] : trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], ~trial[W]};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                OP_MUL_S, OP_MUL_T:
                begin
                    prod_reg <= prod_next;
                end
                OP_SUB_S:
                begin
                    s_prev_reg <= s_cur_reg;
                    s_cur_reg  <= s_prev_reg - prod_reg;
                end
                OP_ADVANCE:
                begin
                    t_prev_reg   <= t_cur_reg;
                    t_cur_reg    <= t_prev_reg - prod_reg;
                    rem_prev_reg <= rem_cur_reg;
                    rem_cur_reg  <= acc_reg;
                end
                OP_EMIT:
                begin
                    gcd_reg         <= GCD_W'(rem_prev_reg[OUT_W-1:0]);
                    coef_first_reg  <= s_prev_reg;
                    coef_second_reg <= t_prev_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign gcd_value        = gcd_reg;
    assign coef_first_bits  = coef_first_reg;
    assign coef_second_bits = coef_second_reg;

endmodule

[hdl/extended_gcd_unit_top.sv]
// Each item runs n Euclid steps between its input transfer and its result.
// n is at most about 45 for 31-bit operands; zero second operand gives n = 0.
// Throughput: one item at a time; the next input transfer can be taken the cycle after
// the result is written to the output register, bounded by the bit-serial divider.
// Reset: rst_n asynchronous, active low; clears the step counter and output valid.
`timescale 1ns / 1ps

module extended_gcd_unit_top
    import egcd_pkg::*;
#(
    parameter int VALUE_BITS = 31
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [GCD_W-1:0]         first_operand,
    input  logic [GCD_W-1:0]         second_operand,
    // Output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [GCD_W-1:0]         gcd_value,
    output logic signed [COEF_W-1:0] coef_first,
    output logic signed [COEF_W-1:0] coef_second
);

    // Control word of the current step and status fed back to the jump logic.
    ctl_t  ctl;
    stat_t stat;

    logic [COEF_W-1:0] coef_first_bits;
    logic [COEF_W-1:0] coef_second_bits;

    // Sequencer: steps through the control store. The idle step takes a transfer,
    // then each Euclid step runs test, VALUE_BITS divide steps, and two
    // multiply/subtract pairs for the s and t coefficients. The emit step holds
    // while a finished result still waits in the output register.
    egcd_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    // Datapath: remainder pair, restoring divider, one shared 32x32 multiplier,
    // coefficient pairs kept modulo 2^32, and the output register that parts the
    // result from the next item's work.
    egcd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .first_operand    (first_operand),
        .second_operand   (second_operand),
        .out_stall        (out_stall),
        .stat             (stat),
        .out_valid        (out_valid),
        .gcd_value        (gcd_value),
        .coef_first_bits  (coef_first_bits),
        .coef_second_bits (coef_second_bits)
    );

    // Coefficients leave as two's complement.
    assign coef_first  = $signed(coef_first_bits);
    assign coef_second = $signed(coef_second_bits);

endmodule

[hdl/egcd_checker.sv]
// Port-level checker for the extended gcd unit and its bind.
`timescale 1ns / 1ps
`include "extended_gcd_unit_top_defines.svh"

module egcd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [30:0]        first_operand,
    input logic [30:0]        second_operand,
    input logic               out_valid,
    input logic               out_stall,
    input logic [30:0]        gcd_value,
    input logic signed [31:0] coef_first,
    input logic signed [31:0] coef_second
);

    // A stalled result stays offered.
    `EGCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `EGCD_ASSERT_NEXT(a_out_stable_gcd, out_valid && out_stall, $stable(gcd_value))
    `EGCD_ASSERT_NEXT(a_out_stable_coef, out_valid && out_stall, $stable({coef_first, coef_second}))

    // After a transfer in, the unit is busy with that item.
    `EGCD_ASSERT_NEXT(a_busy_after_load, in_valid && !in_stall, in_stall)

    // A new result only comes out of a busy unit.
    `EGCD_ASSERT_IMPL(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind extended_gcd_unit_top egcd_checker u_egcd_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the extended gcd unit: directed, pressure and random operand pairs.
`timescale 1ns / 1ps

module tb;
    import egcd_pkg::*;

    // Largest operand the 31-bit ports can carry.
    localparam logic [GCD_W-1:0] OPERAND_MAX = {GCD_W{1'b1}};

    // Consecutive Fibonacci numbers give the longest Euclid chain that fits.
    localparam logic [GCD_W-1:0] FIB_HIGH = 31'd1836311903;
    localparam logic [GCD_W-1:0] FIB_LOW  = 31'd1134903170;

    // Idle cycles with no transfer on either channel before the run is abandoned.
    // The worst single item runs the longest Euclid chain, and the long hold-off
    // adds its own length on top of that.
    localparam int WATCHDOG_LIMIT = 20000;

    // Length of the receiver hold-off used to back the block up: long enough for
    // the item still in flight to finish and the next one to wait behind it.
    localparam int HOLD_OFF_CYCLES = 4000;

    // Cycles to keep watching after the last expected result has arrived.
    localparam int DRAIN_CYCLES = 2000;

    localparam int RANDOM_ITEMS = 780;

    // One expected result, along with the operands that produced it.
    typedef struct {
        logic [GCD_W-1:0]         first_in;
        logic [GCD_W-1:0]         second_in;
        logic [GCD_W-1:0]         gcd_value;
        logic signed [COEF_W-1:0] coef_first;
        logic signed [COEF_W-1:0] coef_second;
        int                       steps;
    } bezout_t;

    logic                     clk            = 1'b0;
    logic                     rst_n          = 1'b0;
    logic                     in_valid       = 1'b0;
    logic                     in_stall;
    logic [GCD_W-1:0]         first_operand  = '0;
    logic [GCD_W-1:0]         second_operand = '0;
    logic                     out_valid;
    logic                     out_stall      = 1'b0;
    logic [GCD_W-1:0]         gcd_value;
    logic signed [COEF_W-1:0] coef_first;
    logic signed [COEF_W-1:0] coef_second;

    // Results still owed by the block, oldest first.
    bezout_t pending_bezout[$];

    int error_count     = 0;
    int items_sent      = 0;
    int directed_items  = 0;
    int results_checked = 0;
    int longest_chain   = 0;
    int stalled_inputs  = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;

    // Set by the pressure test, picked up and cleared by the receiver process.
    bit hold_pending = 1'b0;

    extended_gcd_unit_top #(
        .VALUE_BITS(31)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gcd_value      (gcd_value),
        .coef_first     (coef_first),
        .coef_second    (coef_second)
    );

    always #6 clk = ~clk;

    // Extended Euclid on 64-bit wrapping values. Each step replaces the
    // coefficient pair with previous minus quotient times current; the
    // result comes from the pair that was current when the remainder hit zero.
    function automatic bezout_t bezout_of(input logic [GCD_W-1:0] a,
                                          input logic [GCD_W-1:0] b);
        bezout_t         res;
        longint unsigned rem_prev;
        longint unsigned rem_cur;
        longint unsigned s_prev;
        longint unsigned t_prev;
        longint unsigned s_cur;
        longint unsigned t_cur;
        longint unsigned quot;
        longint unsigned rem_next;
        longint unsigned s_next;
        longint unsigned t_next;
        rem_prev = longint'(a);
        rem_cur  = longint'(b);
        s_prev   = 1;
        t_prev   = 0;
        s_cur    = 0;
        t_cur    = 1;
        res.steps = 0;
        while (rem_cur != 0)
        begin
            quot     = rem_prev / rem_cur;
            rem_next = rem_prev - quot * rem_cur;
            s_next   = s_prev - quot * s_cur;
            t_next   = t_prev - quot * t_cur;
            rem_prev = rem_cur;
            rem_cur  = rem_next;
            s_prev   = s_cur;
            t_prev   = t_cur;
            s_cur    = s_next;
            t_cur    = t_next;
            res.steps++;
        end
        res.first_in    = a;
        res.second_in   = b;
        res.gcd_value   = rem_prev[GCD_W-1:0];
        res.coef_first  = s_prev[COEF_W-1:0];
        res.coef_second = t_prev[COEF_W-1:0];
        return res;
    endfunction

    // Offer one operand pair and hold it until the block takes it. Between
    // bursts of random length, drop valid for a random gap; a gap of zero
    // keeps valid high across the burst boundary.
    task automatic send_operands(input logic [GCD_W-1:0] a, input logic [GCD_W-1:0] b);
        int      gap;
        bezout_t want;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid       <= 1'b1;
        first_operand  <= a;
        second_operand <= b;
        // Values read right after the edge are the ones the block saw at it.
        do
        begin
            @(posedge clk);
            if (in_stall)
                stalled_inputs++;
        end
        while (in_stall);
        want = bezout_of(a, b);
        if (want.steps > longest_chain)
            longest_chain = want.steps;
        pending_bezout.insert(pending_bezout.size(), want);
        items_sent++;
    endtask

    // Zero operands: zero second gives (first, 1, 0); zero first swaps then stops.
    task automatic test_zero_operands();
        send_operands('0, '0);
        send_operands(31'd12345, '0);
        send_operands(OPERAND_MAX, '0);
        send_operands('0, 31'd777);
        send_operands('0, OPERAND_MAX);
    endtask

    // Field extremes and bit patterns.
    task automatic test_extremes();
        send_operands(OPERAND_MAX, OPERAND_MAX);
        send_operands(OPERAND_MAX, 31'd1);
        send_operands(31'd1, OPERAND_MAX);
        send_operands(OPERAND_MAX, OPERAND_MAX - 31'd1);
        send_operands(31'd1, 31'd1);
        send_operands(31'h2AAA_AAAA, 31'h5555_5555);
        send_operands(31'h4000_0000, 31'h2000_0000);
        send_operands(OPERAND_MAX, 31'd2147483629);
        send_operands(31'd1000000007, 31'd998244353);
    endtask

    // Both operand orders; with the first operand smaller, the opening quotient
    // is zero and swaps the pair, while the coefficients must still follow the original order.
    task automatic test_swap_order();
        send_operands(31'd48, 31'd180);
        send_operands(31'd180, 31'd48);
        send_operands(31'd3, OPERAND_MAX - 31'd5);
    endtask

    // Longest Euclid chains, in both orders.
    task automatic test_worst_case_steps();
        send_operands(FIB_HIGH, FIB_LOW);
        send_operands(FIB_LOW, FIB_HIGH);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering
    // pairs back to back, so the block fills up and pushes back on its input.
    task automatic test_output_backpressure();
        int idx;
        hold_pending = 1'b1;
        burst_left   = 10;
        for (idx = 0; idx < 10; idx++)
            send_operands(31'($urandom_range(1, 100000)), 31'($urandom_range(1, 100000)));
    endtask

    // Random pairs: full-range for the largest share, with zero, swapped, small,
    // shared-factor, near-Fibonacci and equal pairs mixed in.
    task automatic test_random_pairs();
        int               idx;
        int               pick;
        logic [GCD_W-1:0] a;
        logic [GCD_W-1:0] b;
        logic [GCD_W-1:0] tmp;
        int unsigned      factor;
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            pick = $urandom_range(99);
            a = 31'($urandom());
            b = 31'($urandom());
            if (pick < 45)
            begin
                // full-range pair, as drawn
            end
            else if (pick < 60)
            begin
                a = 31'($urandom_range(0, 255));
                b = 31'($urandom_range(0, 255));
            end
            else if (pick < 68)
            begin
                if ($urandom_range(1))
                    b = '0;
                else
                    a = '0;
            end
            else if (pick < 80)
            begin
                // put the smaller operand first
                if (a > b)
                begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end
            else if (pick < 92)
            begin
                factor = $urandom_range(2, 60000);
                a = 31'(factor * $urandom_range(0, 32'h7FFF_FFFF / factor));
                b = 31'(factor * $urandom_range(0, 32'h7FFF_FFFF / factor));
            end
            else if (pick < 96)
            begin
                a = FIB_HIGH - 31'($urandom_range(0, 3));
                b = FIB_LOW + 31'($urandom_range(0, 3));
            end
            else
            begin
                b = a;
            end
            send_operands(a, b);
        end
    endtask

    // Receiver: stall on a pattern of its own, switching between stretches of
    // no stalling, light, heavy and near-total stalling. A requested hold-off
    // overrides the pattern for a fixed number of cycles.
    always @(posedge clk)
    begin : receiver_stall
        static int mode_left       = 0;
        static int stall_pct       = 0;
        static int hold_cycles_left = 0;
        if (hold_pending)
        begin
            hold_pending     = 1'b0;
            hold_cycles_left = HOLD_OFF_CYCLES;
        end
        if (mode_left == 0)
        begin
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        if (hold_cycles_left > 0)
        begin
            hold_cycles_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        bezout_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bezout.size() == 0)
            begin
                $error("result with nothing expected: gcd %0d, s %0d, t %0d",
                       gcd_value, coef_first, coef_second);
                error_count++;
            end
            else
            begin
                want = pending_bezout.pop_front();
                results_checked++;
                if (gcd_value !== want.gcd_value)
                begin
                    $error("gcd_value for (%0d, %0d): expected %0d, actual %0d",
                           want.first_in, want.second_in, want.gcd_value, gcd_value);
                    error_count++;
                end
                if (coef_first !== want.coef_first)
                begin
                    $error("coef_first for (%0d, %0d): expected %0d, actual %0d",
                           want.first_in, want.second_in, want.coef_first, coef_first);
                    error_count++;
                end
                if (coef_second !== want.coef_second)
                begin
                    $error("coef_second for (%0d, %0d): expected %0d, actual %0d",
                           want.first_in, want.second_in, want.coef_second, coef_second);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d idle cycles, %0d results outstanding",
                         idle_cycles, pending_bezout.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        // Hold reset, then release it on a clock edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_operands();
        test_extremes();
        test_swap_order();
        test_worst_case_steps();
        directed_items = items_sent;
        test_output_backpressure();
        test_random_pairs();
        in_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (pending_bezout.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_bezout.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_bezout.size());
            error_count++;
        end

        $display("Covered %0d operand pairs (%0d directed), %0d results checked.",
                 items_sent, directed_items, results_checked);
        $display("Longest Euclid chain %0d steps; input held back on %0d cycles.",
                 longest_chain, stalled_inputs);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[extended_gcd_unit_top.f]
+incdir+hdl
hdl/egcd_pkg.sv
hdl/egcd_seq.sv
hdl/egcd_dp.sv
hdl/extended_gcd_unit_top.sv
hdl/egcd_checker.sv
verif/tb.sv
